// File: rtl/tkd_pkg.sv
// Shared types, key codes and decode functions for the terminal key decoder.
package tkd_pkg;

   localparam int ScreenWidth = 10;

   // Key codes on the result channel
   localparam logic [8:0] KEY_ESC   = 9'h01b;
   localparam logic [8:0] KEY_QUIT  = 9'h011;
   localparam logic [8:0] KEY_LEFT  = 9'd256;
   localparam logic [8:0] KEY_RIGHT = 9'd257;
   localparam logic [8:0] KEY_UP    = 9'd258;
   localparam logic [8:0] KEY_DOWN  = 9'd259;
   localparam logic [8:0] KEY_HOME  = 9'd260;
   localparam logic [8:0] KEY_DEL   = 9'd261;
   localparam logic [8:0] KEY_END   = 9'd262;
   localparam logic [8:0] KEY_PGUP  = 9'd263;
   localparam logic [8:0] KEY_PGDN  = 9'd264;

   // Input characters
   localparam logic [7:0] CH_ESC     = 8'h1b;
   localparam logic [7:0] CH_TILDE   = 8'h7e;
   localparam logic [7:0] CH_BRACKET = 8'h5b;
   localparam logic [7:0] CH_UPPER_O = 8'h4f;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;

   // Command codes
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_TIMEOUT = 1'b1;

   // Register indexes (word address bit)
   localparam logic REG_SCREEN_ROWS = 1'b0;
   localparam logic REG_SCREEN_COLS = 1'b1;

   localparam logic [ScreenWidth-1:0] ROWS_RESET = 10'd24;
   localparam logic [ScreenWidth-1:0] COLS_RESET = 10'd80;

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_ESC   = 3'd1,
      PH_FIRST = 3'd2,
      PH_DIGIT = 3'd3
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [7:0]             first_seq_byte;
      logic [7:0]             held_digit;
      logic [ScreenWidth-1:0] col_pos;
      logic [ScreenWidth-1:0] row_pos;
   } state_type;

   typedef struct packed {
      logic                   key_valid;
      logic [8:0]             key_code;
      logic                   quit;
      logic [ScreenWidth-1:0] cursor_col;
      logic [ScreenWidth-1:0] cursor_row;
   } result_type;

   function automatic logic [8:0] letter_key(input logic [7:0] b);
      logic [8:0] k;
      case (b)
         8'h41:   k = KEY_UP;
         8'h42:   k = KEY_DOWN;
         8'h43:   k = KEY_RIGHT;
         8'h44:   k = KEY_LEFT;
         8'h48:   k = KEY_HOME;
         8'h46:   k = KEY_END;
         default: k = KEY_ESC;
      endcase
      return k;
   endfunction

   function automatic logic [8:0] digit_key(input logic [7:0] d);
      logic [8:0] k;
      case (d)
         8'h31, 8'h37: k = KEY_HOME;
         8'h33:        k = KEY_DEL;
         8'h34, 8'h38: k = KEY_END;
         8'h35:        k = KEY_PGUP;
         8'h36:        k = KEY_PGDN;
         default:      k = KEY_ESC;
      endcase
      return k;
   endfunction

endpackage

// File: rtl/tkd_step.sv
// One decode step: escape parser and cursor update for a single transfer.
module tkd_step (
   input  tkd_pkg::state_type               state_cur,
   input  logic                             cmd,
   input  logic [7:0]                       in_byte,
   input  logic [tkd_pkg::ScreenWidth-1:0]  screen_rows,
   input  logic [tkd_pkg::ScreenWidth-1:0]  screen_cols,
   output tkd_pkg::state_type               state_next,
   output tkd_pkg::result_type              result
);
   import tkd_pkg::*;

   logic                   timeout;
   logic                   is_digit;
   logic                   key_valid;
   logic [8:0]             key_code;
   phase_type              phase_next;
   logic [ScreenWidth-1:0] last_col;
   logic [ScreenWidth-1:0] last_row;
   logic [ScreenWidth-1:0] col_clamp;
   logic [ScreenWidth-1:0] row_clamp;
   logic [ScreenWidth-1:0] col_next;
   logic [ScreenWidth-1:0] row_next;

   assign timeout  = (cmd == CMD_TIMEOUT);
   assign is_digit = (in_byte >= CH_DIGIT_0) && (in_byte <= CH_DIGIT_9);

   // Next parse phase
   always_comb begin
      phase_next = PH_IDLE;
      case (state_cur.phase)
         PH_ESC: begin
            phase_next = timeout ? PH_IDLE : PH_FIRST;
         end
         PH_FIRST: begin
            if (!timeout && state_cur.first_seq_byte == CH_BRACKET && is_digit) begin
               phase_next = PH_DIGIT;
            end
         end
         PH_DIGIT: phase_next = PH_IDLE;
         default: begin
            if (!timeout && in_byte == CH_ESC) begin
               phase_next = PH_ESC;
            end
         end
      endcase
   end

   // Key decode
   always_comb begin
      key_valid = 1'b0;
      key_code  = '0;
      case (state_cur.phase)
         PH_ESC: begin
            if (timeout) begin
               key_valid = 1'b1;
               key_code  = KEY_ESC;
            end
         end
         PH_FIRST: begin
            if (timeout) begin
               key_valid = 1'b1;
               key_code  = KEY_ESC;
            end else if (!(state_cur.first_seq_byte == CH_BRACKET && is_digit)) begin
               key_valid = 1'b1;
               if (state_cur.first_seq_byte == CH_BRACKET) begin
                  key_code = letter_key(in_byte);
               end else if (state_cur.first_seq_byte == CH_UPPER_O &&
                            (in_byte == 8'h48 || in_byte == 8'h46)) begin
                  key_code = letter_key(in_byte);
               end else begin
                  key_code = KEY_ESC;
               end
            end
         end
         PH_DIGIT: begin
            key_valid = 1'b1;
            key_code  = (!timeout && in_byte == CH_TILDE) ?
                        digit_key(state_cur.held_digit) : KEY_ESC;
         end
         default: begin
            if (!timeout && in_byte != CH_ESC) begin
               key_valid = 1'b1;
               key_code  = {1'b0, in_byte};
            end
         end
      endcase
   end

   // Cursor: zero-size screen acts as one; clamp before moving
   assign last_col  = (screen_cols == '0) ? '0 : screen_cols - 1'b1;
   assign last_row  = (screen_rows == '0) ? '0 : screen_rows - 1'b1;
   assign col_clamp = (state_cur.col_pos > last_col) ? last_col : state_cur.col_pos;
   assign row_clamp = (state_cur.row_pos > last_row) ? last_row : state_cur.row_pos;

   always_comb begin
      col_next = state_cur.col_pos;
      row_next = state_cur.row_pos;
      if (key_valid) begin
         col_next = col_clamp;
         row_next = row_clamp;
         case (key_code)
            KEY_LEFT:  if (col_clamp != '0)      col_next = col_clamp - 1'b1;
            KEY_RIGHT: if (col_clamp < last_col) col_next = col_clamp + 1'b1;
            KEY_UP:    if (row_clamp != '0)      row_next = row_clamp - 1'b1;
            KEY_DOWN:  if (row_clamp < last_row) row_next = row_clamp + 1'b1;
            KEY_HOME:  col_next = '0;
            KEY_END:   col_next = last_col;
            KEY_PGUP:  row_next = '0;
            KEY_PGDN:  row_next = last_row;
            default:   ;
         endcase
      end
   end

   always_comb begin
      state_next       = state_cur;
      state_next.phase = phase_next;
      if (state_cur.phase == PH_ESC && !timeout) begin
         state_next.first_seq_byte = in_byte;
      end
      if (state_cur.phase == PH_FIRST && phase_next == PH_DIGIT) begin
         state_next.held_digit = in_byte;
      end
      state_next.col_pos = col_next;
      state_next.row_pos = row_next;
   end

   assign result.key_valid  = key_valid;
   assign result.key_code   = key_code;
   assign result.quit       = key_valid && (key_code == KEY_QUIT);
   assign result.cursor_col = col_next;
   assign result.cursor_row = row_next;

endmodule

// File: rtl/terminal_key_decoder_cursor_unit.sv
// Top level: terminal escape-sequence key decoder with cursor tracking.
// Path: an input transfer goes into the input register, then is decoded
//   into the result register, from which the result is offered.
// Throughput: one transfer per cycle unless the result channel stalls;
//   the parse/cursor state updates with each decoded item, so
//   consecutive bytes never wait on each other.
// Reset (synchronous): parser idle, cursor at 0,0, screen 24 rows x 80 cols.
module terminal_key_decoder_cursor_unit (
   input  logic                             clock,
   input  logic                             reset,
   // input channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [7:0]                       req_in_byte,
   // result channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_key_valid,
   output logic [8:0]                       rsp_key_code,
   output logic                             rsp_quit,
   output logic [tkd_pkg::ScreenWidth-1:0]  rsp_cursor_col,
   output logic [tkd_pkg::ScreenWidth-1:0]  rsp_cursor_row,
   // configuration port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [2:0]                       csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);
   import tkd_pkg::*;

   // Input register
   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;

   // Decoder state and result register
   state_type  state_ff, state_in;
   result_type rsp_ff, step_result;
   logic       rsp_valid_ff, rsp_valid_in;

   // Screen size registers
   logic [ScreenWidth-1:0] rows_ff, rows_in;
   logic [ScreenWidth-1:0] cols_ff, cols_in;

   logic out_free;
   logic advance;
   logic in_take;
   logic csr_write;

   // The result register frees up when empty or when its transfer completes.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign in_take   = req_valid && !req_stall;

   assign in_valid_in  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (out_free ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Payload held while the input register is stalled
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_in_byte;
      end
   end

   tkd_step u_step (
      .state_cur   (state_ff),
      .cmd         (in_cmd_ff),
      .in_byte     (in_byte_ff),
      .screen_rows (rows_ff),
      .screen_cols (cols_ff),
      .state_next  (state_in),
      .result      (step_result)
   );

   // State moves only when the decoded item goes into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase          <= PH_IDLE;
         state_ff.first_seq_byte <= '0;
         state_ff.held_digit     <= '0;
         state_ff.col_pos        <= '0;
         state_ff.row_pos        <= '0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         if (advance) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_valid  = rsp_ff.key_valid;
   assign rsp_key_code   = rsp_ff.key_code;
   assign rsp_quit       = rsp_ff.quit;
   assign rsp_cursor_col = rsp_ff.cursor_col;
   assign rsp_cursor_row = rsp_ff.cursor_row;

   // Config: word address picks the register, low address bits are byte offset.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            REG_SCREEN_ROWS: rows_in = csr_pwdata[ScreenWidth-1:0];
            REG_SCREEN_COLS: cols_in = csr_pwdata[ScreenWidth-1:0];
            default:         ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= ROWS_RESET;
         cols_ff <= COLS_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      case (csr_paddr[2])
         REG_SCREEN_ROWS: csr_prdata = {{(32-ScreenWidth){1'b0}}, rows_ff};
         REG_SCREEN_COLS: csr_prdata = {{(32-ScreenWidth){1'b0}}, cols_ff};
         default:         csr_prdata = '0;
      endcase
   end

   // Assertions
   a_nokey_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_key_valid) |-> (rsp_key_code == '0 && !rsp_quit))
      else $error("result without key carries a code or quit");

   a_quit_code: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_quit) |-> (rsp_key_valid && rsp_key_code == KEY_QUIT))
      else $error("quit raised for a key other than ctrl-q");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("input stalled with room in the pipeline");

   a_digit_ends: assert property (@(posedge clock) disable iff (reset)
      (advance && state_ff.phase == PH_DIGIT) |=> (state_ff.phase == PH_IDLE &&
                                                   rsp_key_valid))
      else $error("sequence did not finish after the digit byte");

endmodule
